// ----- rtl/lruhc_pkg.sv -----
// ---------------------------------------------------------------------------
// lruhc_pkg: shared types for the LRU cache hit counter
// Item payloads for the request and response channels and the update
// controls broadcast from the top level to the row of entry cells.
// ---------------------------------------------------------------------------
package lruhc_pkg;

   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 32;
   localparam int WAYS_W  = 5;
   localparam int CSR_W   = 32;

   localparam logic [WAYS_W-1:0] WAYS_RESET = 5'd16;

   typedef struct packed {
      logic [ADDR_W-1:0]  address;
      logic [COUNT_W-1:0] run_count;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [COUNT_W-1:0] access_total;
      logic [COUNT_W-1:0] hit_total;
      logic [COUNT_W-1:0] miss_total;
   } rsp_type;

   // update: an item is applied this cycle
   // hit:    lookup matched a valid entry
   // fill:   miss with a free way, load the next free entry
   // neither hit nor fill on update: replace the least recent entry
   typedef struct packed {
      logic update;
      logic hit;
      logic fill;
   } ctl_type;

endpackage

// ----- rtl/lruhc_cell.sv -----
// ---------------------------------------------------------------------------
// lruhc_cell: one cache entry
// Holds tag, valid bit and recency rank. Compares the broadcast address,
// merges its match into the hit/rank chain from its neighbor and applies
// the LRU update for the item.
// ---------------------------------------------------------------------------
module lruhc_cell #(
   parameter int RANK_W = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [lruhc_pkg::ADDR_W-1:0] address,
   input  lruhc_pkg::ctl_type           ctl,
   input  logic [RANK_W-1:0]            limit,
   input  logic                         fill_sel,
   input  logic                         hit_in,
   input  logic [RANK_W-1:0]            rank_in,
   output logic                         hit_out,
   output logic [RANK_W-1:0]            rank_out,
   output logic                         valid
);
   import lruhc_pkg::*;

   logic [ADDR_W-1:0] tag_ff;
   logic [ADDR_W-1:0] tag_in;
   logic              valid_ff;
   logic              valid_in;
   logic [RANK_W-1:0] rank_ff;
   logic [RANK_W-1:0] rank_in_nxt;
   logic              match;
   logic              older;

   assign match    = valid_ff && (tag_ff == address);
   assign hit_out  = hit_in | match;
   assign rank_out = rank_in | (match ? rank_ff : '0);
   assign valid    = valid_ff;
   assign older    = valid_ff && (rank_ff < limit);

   always_comb begin
      tag_in      = tag_ff;
      valid_in    = valid_ff;
      rank_in_nxt = rank_ff;
      if (ctl.update) begin
         if (ctl.hit) begin
            if (match) begin
               rank_in_nxt = '0;
            end else if (older) begin
               rank_in_nxt = rank_ff + RANK_W'(1);
            end
         end else if (ctl.fill) begin
            if (fill_sel) begin
               valid_in    = 1'b1;
               tag_in      = address;
               rank_in_nxt = '0;
            end else if (valid_ff) begin
               rank_in_nxt = rank_ff + RANK_W'(1);
            end
         end else begin
            if (valid_ff && (rank_ff == limit)) begin
               tag_in      = address;
               rank_in_nxt = '0;
            end else if (older) begin
               rank_in_nxt = rank_ff + RANK_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in_nxt;
      end
   end

endmodule

// ----- rtl/lru_cache_hit_counter.sv -----
// ---------------------------------------------------------------------------
// lru_cache_hit_counter: fully associative LRU cache hit counter
// Replays run-length trace items against a row of entry cells and keeps
// wrapping totals of accesses, hits and misses.
// ---------------------------------------------------------------------------
// Usage:
//   Request: drive req_item (address, run_count) with start high; the item is
//   taken at the clock edge where start is high and busy is low. busy stays
//   low, so one item can be taken every cycle.
//   Response: one item per request, on rsp_item with rsp_valid high for
//   exactly one cycle, the cycle after the request was taken.
//   The receiver has no back-pressure; each response must be captured when
//   rsp_valid is high.
//   Throughput: 1 item per cycle. Lookup, LRU update and counter update all
//   complete in the accept cycle; the path runs through the address compare
//   in every cell and the hit/rank chain along the row.
//   Config: ways_in_use at byte address 0 on the APB port; write only while
//   no response is pending. 0 acts as 1, values above ENTRIES as ENTRIES.
//   Reset: all entries invalid, counters zero, ways_in_use = 16.
// ---------------------------------------------------------------------------
module lru_cache_hit_counter #(
   parameter int ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lruhc_pkg::req_type            req_item,
   output logic                          rsp_valid,
   output lruhc_pkg::rsp_type            rsp_item,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [1:0]                    paddr,
   input  logic [lruhc_pkg::CSR_W-1:0]   pwdata,
   output logic [lruhc_pkg::CSR_W-1:0]   prdata,
   output logic                          pready
);
   import lruhc_pkg::*;

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int MAX_W  = (CNT_W > WAYS_W) ? CNT_W : WAYS_W;

   logic [WAYS_W-1:0]  ways_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [COUNT_W-1:0] acc_ff;
   logic [COUNT_W-1:0] acc_in;
   logic [COUNT_W-1:0] hits_ff;
   logic [COUNT_W-1:0] hits_in;
   logic [COUNT_W-1:0] miss_ff;
   logic [COUNT_W-1:0] miss_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_item_ff;

   logic               accept;
   logic [COUNT_W-1:0] run_eff;
   logic [MAX_W-1:0]   ways_x;
   logic [MAX_W-1:0]   ways_eff;
   logic               fill;
   logic               hit;
   logic [CNT_W-1:0]   count_dec;
   logic [RANK_W-1:0]  limit;
   ctl_type            ctl;

   logic                  hit_chain  [ENTRIES+1];
   logic [RANK_W-1:0]     rank_chain [ENTRIES+1];
   logic [ENTRIES-1:0]    valid_vec;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign prdata = {{(CSR_W-WAYS_W){1'b0}}, ways_ff};
   assign accept = start && !busy;

   assign run_eff = (req_item.run_count == '0) ? COUNT_W'(1) : req_item.run_count;

   always_comb begin
      ways_x = MAX_W'(ways_ff);
      if (ways_x == '0) begin
         ways_eff = MAX_W'(1);
      end else if (ways_x > MAX_W'(ENTRIES)) begin
         ways_eff = MAX_W'(ENTRIES);
      end else begin
         ways_eff = ways_x;
      end
   end

   assign hit_chain[0]  = 1'b0;
   assign rank_chain[0] = '0;
   assign hit           = hit_chain[ENTRIES];
   assign fill          = MAX_W'(count_ff) < ways_eff;
   assign count_dec     = count_ff - CNT_W'(1);
   assign limit         = hit ? rank_chain[ENTRIES] : count_dec[RANK_W-1:0];

   assign ctl.update = accept;
   assign ctl.hit    = hit;
   assign ctl.fill   = fill;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lruhc_cell #(
         .RANK_W(RANK_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .address  (req_item.address),
         .ctl      (ctl),
         .limit    (limit),
         .fill_sel (count_ff == CNT_W'(i)),
         .hit_in   (hit_chain[i]),
         .rank_in  (rank_chain[i]),
         .hit_out  (hit_chain[i+1]),
         .rank_out (rank_chain[i+1]),
         .valid    (valid_vec[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      acc_in   = acc_ff;
      hits_in  = hits_ff;
      miss_in  = miss_ff;
      if (accept) begin
         acc_in = acc_ff + run_eff;
         if (hit) begin
            hits_in = hits_ff + run_eff;
         end else begin
            hits_in = hits_ff + (run_eff - COUNT_W'(1));
            miss_in = miss_ff + COUNT_W'(1);
            if (fill) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff      <= WAYS_RESET;
         count_ff     <= '0;
         acc_ff       <= '0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            ways_ff <= pwdata[WAYS_W-1:0];
         end
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         hits_ff      <= hits_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff.hit          <= hit;
         rsp_item_ff.access_total <= acc_in;
         rsp_item_ff.hit_total    <= hits_in;
         rsp_item_ff.miss_total   <= miss_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("response missing after accepted item");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("response without accepted item");

   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("valid entries disagree with fill count");

   a_hit_keeps_misses: assert property (@(posedge clock) disable iff (reset)
      (accept && hit) |=> (miss_ff == $past(miss_ff)))
      else $error("miss total changed on a hit");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= ENTRIES)
      else $error("fill count exceeds entry count");

endmodule

// ----- tb/lru_cache_hit_counter_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lru_cache_hit_counter_tb: self-checking bench for the LRU cache hit counter
// A short directed table (extremes, zero runs, wrapping totals, ways register
// out of range and lowered while filled) is followed by random phases. Each
// phase sets the ways register and replays traces drawn from a small working
// set. Every response is compared against an LRU cache predictor kept in the
// bench, or against the values given in the directed table.
// ---------------------------------------------------------------------------
module lru_cache_hit_counter_tb;
   import lruhc_pkg::*;

   localparam int ENTRIES      = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 170;
   localparam logic [1:0] WAYS_ADDR = 2'd0;

   typedef enum {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      req_type            req;
      bit                 known;
      rsp_type            rsp;
      logic [CSR_W-1:0]   csr_value;
   } plan_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_type            req_item = '0;
   logic               rsp_valid;
   rsp_type            rsp_item;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [1:0]         paddr = '0;
   logic [CSR_W-1:0]   pwdata = '0;
   logic [CSR_W-1:0]   prdata;
   logic               pready;

   // predictor state
   logic [ADDR_W-1:0]  tag_q[ENTRIES];
   bit                 held[ENTRIES];
   int                 age[ENTRIES];
   logic [COUNT_W-1:0] access_sum = '0;
   logic [COUNT_W-1:0] hit_sum = '0;
   logic [COUNT_W-1:0] miss_sum = '0;
   logic [WAYS_W-1:0]  ways_cfg = WAYS_RESET;

   rsp_type            rsp_due[$];
   plan_row_type       plan[$];
   int                 error_count = 0;
   int                 cycles = 0;

   lru_cache_hit_counter #(.ENTRIES(ENTRIES)) i_dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("lru_cache_hit_counter_tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp_valid) begin
         if (rsp_due.size() == 0) begin
            $error("unexpected response item");
            error_count++;
         end else begin
            exp = rsp_due.pop_front();
            if (rsp_item.hit !== exp.hit) begin
               $error("hit: expected %0d, got %0d", exp.hit, rsp_item.hit);
               error_count++;
            end
            if (rsp_item.access_total !== exp.access_total) begin
               $error("access_total: expected %h, got %h",
                      exp.access_total, rsp_item.access_total);
               error_count++;
            end
            if (rsp_item.hit_total !== exp.hit_total) begin
               $error("hit_total: expected %h, got %h",
                      exp.hit_total, rsp_item.hit_total);
               error_count++;
            end
            if (rsp_item.miss_total !== exp.miss_total) begin
               $error("miss_total: expected %h, got %h",
                      exp.miss_total, rsp_item.miss_total);
               error_count++;
            end
         end
      end
   end

   function automatic void age_older(int limit);
      for (int i = 0; i < ENTRIES; i++)
         if (held[i] && age[i] < limit) age[i]++;
   endfunction

   function automatic rsp_type lru_access(req_type r);
      logic [COUNT_W-1:0] run;
      int ways;
      int count;
      int found;
      int slot;
      rsp_type res;
      run = (r.run_count == '0) ? 1 : r.run_count;
      ways = (ways_cfg == 0) ? 1 : ((ways_cfg > ENTRIES) ? ENTRIES : int'(ways_cfg));
      count = 0;
      found = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (held[i]) begin
            count++;
            if (found < 0 && tag_q[i] == r.address) found = i;
         end
      end
      access_sum += run;
      if (found >= 0) begin
         hit_sum += run;
         age_older(age[found]);
         age[found] = 0;
      end else begin
         miss_sum += 1;
         hit_sum += run - 1;
         slot = 0;
         if (count < ways) begin
            slot = count;
            age_older(ENTRIES + 1);
            held[slot] = 1'b1;
         end else begin
            for (int i = 0; i < ENTRIES; i++)
               if (held[i] && age[i] == count - 1) slot = i;
            age_older(count - 1);
         end
         tag_q[slot] = r.address;
         age[slot] = 0;
      end
      res.hit = (found >= 0);
      res.access_total = access_sum;
      res.hit_total = hit_sum;
      res.miss_total = miss_sum;
      return res;
   endfunction

   task automatic send_item(input req_type r, input bit known, input rsp_type typed,
                            input bit burst);
      int gap;
      rsp_type exp;
      gap = burst ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      exp = lru_access(r);
      if (known) exp = typed;
      rsp_due = {rsp_due, exp};
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic check_ways();
      logic [CSR_W-1:0] rd;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= WAYS_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (rd[WAYS_W-1:0] !== ways_cfg) begin
         $error("ways_in_use: expected %0d, got %0d", ways_cfg, rd[WAYS_W-1:0]);
         error_count++;
      end
   endtask

   // the read-back transfer follows the write directly
   task automatic set_ways(input logic [CSR_W-1:0] value);
      wait_drained();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= WAYS_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      ways_cfg = value[WAYS_W-1:0];
      check_ways();
   endtask

   task automatic add_item(input logic [ADDR_W-1:0] a, input logic [COUNT_W-1:0] n);
      plan_row_type row;
      row.kind = ROW_ITEM;
      row.req.address = a;
      row.req.run_count = n;
      row.known = 1'b0;
      row.rsp = '0;
      row.csr_value = '0;
      plan = {plan, row};
   endtask

   task automatic add_known(input logic [ADDR_W-1:0] a, input logic [COUNT_W-1:0] n,
                            input logic h, input logic [COUNT_W-1:0] acc,
                            input logic [COUNT_W-1:0] hits,
                            input logic [COUNT_W-1:0] misses);
      add_item(a, n);
      plan[$].known = 1'b1;
      plan[$].rsp.hit = h;
      plan[$].rsp.access_total = acc;
      plan[$].rsp.hit_total = hits;
      plan[$].rsp.miss_total = misses;
   endtask

   task automatic add_csr(input logic [CSR_W-1:0] value);
      plan_row_type row;
      row.kind = ROW_CSR;
      row.req = '0;
      row.known = 1'b0;
      row.rsp = '0;
      row.csr_value = value;
      plan = {plan, row};
   endtask

   initial begin
      logic [ADDR_W-1:0] pool[24];
      int pool_size;
      int ew;
      int pick;
      logic [WAYS_W-1:0] w;
      logic [CSR_W-1:0] wval;
      req_type r;
      bit burst;

      for (int i = 0; i < ENTRIES; i++) begin
         tag_q[i] = '0;
         held[i] = 1'b0;
         age[i] = 0;
      end

      add_known(32'h0000_0000, 32'd1, 1'b0, 32'd1, 32'd0, 32'd1);
      add_known(32'h0000_0000, 32'd0, 1'b1, 32'd2, 32'd1, 32'd1);   // zero run
      add_known(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'd1, 32'hFFFF_FFFF, 32'd2);
      add_known(32'hFFFF_FFFF, 32'd1, 1'b1, 32'd2, 32'd0, 32'd2);
      add_known(32'h0000_0000, 32'd2, 1'b1, 32'd4, 32'd2, 32'd2);
      add_item(32'hAAAA_AAAA, 32'h5555_5555);
      add_item(32'h5555_5555, 32'hAAAA_AAAA);
      add_item(32'h8000_0000, 32'h8000_0000);
      add_csr(32'd0);                           // acts as one way, five held
      add_item(32'h0000_0000, 32'd1);
      add_item(32'h1234_5678, 32'd3);
      add_item(32'h1234_5678, 32'd1);
      add_item(32'hAAAA_AAAA, 32'd1);
      add_csr(32'd31);                          // clamps to ENTRIES
      for (int i = 0; i < 6; i++) add_item(32'h0000_0100 + i, 32'd1);
      add_csr(32'd2);
      add_item(32'h0000_0007, 32'd1);
      add_item(32'h0000_0008, 32'd5);
      add_item(32'h0000_0007, 32'd1);
      add_csr(32'd16);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      check_ways();

      foreach (plan[n]) begin
         if (plan[n].kind == ROW_CSR) set_ways(plan[n].csr_value);
         else send_item(plan[n].req, plan[n].known, plan[n].rsp, 1'b0);
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: w = 5'd1;
            1: w = 5'd16;
            2: w = 5'd0;
            3: w = 5'd31;
            4: w = 5'd4;
            default: w = WAYS_W'($urandom_range(0, 31));
         endcase
         wval = (p % 2 == 1) ? (($urandom() & 32'hFFFF_FFE0) | w) : CSR_W'(w);
         set_ways(wval);
         ew = (w == 0) ? 1 : ((w > ENTRIES) ? ENTRIES : int'(w));
         pool_size = ew + $urandom_range(0, 4);
         for (int k = 0; k < pool_size; k++)
            pool[k] = (k % 2 == 0) ? $urandom() : pool[k-1] ^ (32'd1 << $urandom_range(0, 31));
         burst = (p % 3 == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r.address = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_size - 1)]
                                                      : $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 5) r.run_count = '0;
            else if (pick < 10) r.run_count = $urandom();
            else if (pick < 12) r.run_count = '1;
            else r.run_count = $urandom_range(1, 8);
            send_item(r, 1'b0, '0, burst);
            if ($urandom_range(0, 59) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (error_count == 0) $display("lru_cache_hit_counter_tb: PASS");
      else $display("lru_cache_hit_counter_tb: FAIL");
      $finish;
   end

endmodule
